// ===== src/ctm_pkg.sv =====
`timescale 1ns / 1ps

package ctm_pkg;

    // Tile geometry in Q8.8 units: tiles are 1.5 wide, so 384 = 3 * 128.
    localparam int TILE_SIZE = 384;
    localparam int TILE_MID  = 192;
    // floor(n / 3) == (n * 171) >> 9 for every n up to 259.
    localparam int DIV3_MUL  = 171;
    localparam int DIV3_SHIFT = 9;

    localparam int POS_W  = 15;
    localparam int HALF_W = 9;
    localparam int RSQ_W  = 16;
    localparam int TIDX_W = 8;

    // Signed tile index; with the fixed field widths it spans -2 to 86.
    typedef logic signed [TIDX_W-1:0] tile_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_PROBE_HALF = 1'b0,
        CFG_CORNER_RSQ = 1'b1
    } cfg_idx_t;

    // Input payload, last field in the lowest bits.
    typedef struct packed {
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
        logic             tile_solid;
        logic [5:0]       tile_row;
        logic [5:0]       tile_col;
    } in_data_t;

    // One corner handed to the tile test pipeline.
    typedef struct packed {
        logic             valid;
        logic [1:0]       corner;
        logic             oob;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        tile_idx_t        col;
        tile_idx_t        row;
    } tt_req_t;

    // Outcome for one corner.
    typedef struct packed {
        logic       valid;
        logic [1:0] corner;
        logic       last;
        logic       solid;
        logic       oob;
        logic       hit;
    } tt_rsp_t;

endpackage

// ===== src/ctm_ram.sv =====
`timescale 1ns / 1ps

module ctm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ctm_corner.sv =====
`timescale 1ns / 1ps

module ctm_corner (
    input  logic                      clk,
    input  logic                      ld,
    input  logic [ctm_pkg::POS_W-1:0]  pos,
    input  logic [ctm_pkg::HALF_W-1:0] half,
    output ctm_pkg::tile_idx_t         idx_lo,
    output ctm_pkg::tile_idx_t         idx_hi
);

    import ctm_pkg::*;

    // Floor of a 17-bit two's complement coordinate divided by the tile size.
    // Non-negative values drop the factor 128 by a shift and the factor 3 by a
    // reciprocal multiply. Negative values never go below minus one tile plus
    // a probe half, so they land on tile -1 or -2.
    function automatic tile_idx_t tile_of(input logic [16:0] v);
        logic [16:0] prod;
        tile_idx_t   res;
        prod = 17'(v[15:7]) * 17'(DIV3_MUL);
        if (v[16])
        begin
            res = (v >= 17'(-TILE_SIZE)) ? -8'sd1 : -8'sd2;
        end
        else
        begin
            res = TIDX_W'(prod[16:DIV3_SHIFT]);
        end
        return res;
    endfunction

    logic [16:0] v_lo;
    logic [16:0] v_hi;
    tile_idx_t   idx_lo_reg;
    tile_idx_t   idx_hi_reg;

    assign v_lo = 17'(pos) - 17'(half);
    assign v_hi = 17'(pos) + 17'(half);

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            idx_lo_reg <= tile_of(v_lo);
            idx_hi_reg <= tile_of(v_hi);
        end
    end

    assign idx_lo = idx_lo_reg;
    assign idx_hi = idx_hi_reg;

endmodule

// ===== src/ctm_tile_test.sv =====
`timescale 1ns / 1ps

module ctm_tile_test (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctm_pkg::tt_req_t           req,
    input  logic                       map_solid,
    input  logic [ctm_pkg::HALF_W-1:0] half,
    input  logic [ctm_pkg::RSQ_W-1:0]  rsq,
    output ctm_pkg::tt_rsp_t           rsp
);

    import ctm_pkg::*;

    // Stage 0: distances from the tile centre and the per-axis limits.
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [17:0]        xd;
    logic [17:0]        yd;
    logic [17:0]        lim;
    logic [17:0]        exw;
    logic [17:0]        eyw;

    always_comb
    begin
        cx  = 18'(req.col) * 18'sd384 + 18'sd192;
        cy  = 18'(req.row) * 18'sd384 + 18'sd192;
        dx  = $signed(18'(req.px)) - cx;
        dy  = $signed(18'(req.py)) - cy;
        xd  = dx[17] ? 18'(-dx) : 18'(dx);
        yd  = dy[17] ? 18'(-dy) : 18'(dy);
        lim = 18'(half) + 18'(TILE_MID);
        exw = xd - 18'(TILE_MID);
        eyw = yd - 18'(TILE_MID);
    end

    logic             v1_reg;
    logic [1:0]       corner1_reg;
    logic             oob1_reg;
    logic             rej1_reg;
    logic             acc1_reg;
    logic [HALF_W-1:0] ex1_reg;
    logic [HALF_W-1:0] ey1_reg;

    // Stage 1: the map bit arrives from the memory; square the corner offsets.
    logic             v2_reg;
    logic [1:0]       corner2_reg;
    logic             oob2_reg;
    logic             solid2_reg;
    logic             rej2_reg;
    logic             acc2_reg;
    logic [2*HALF_W-1:0] exsq2_reg;
    logic [2*HALF_W-1:0] eysq2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        corner1_reg <= req.corner;
        oob1_reg    <= req.oob;
        rej1_reg    <= (xd > lim) || (yd > lim);
        acc1_reg    <= (xd <= 18'(TILE_MID)) || (yd <= 18'(TILE_MID));
        ex1_reg     <= exw[HALF_W-1:0];
        ey1_reg     <= eyw[HALF_W-1:0];

        corner2_reg <= corner1_reg;
        oob2_reg    <= oob1_reg;
        solid2_reg  <= oob1_reg | map_solid;
        rej2_reg    <= rej1_reg;
        acc2_reg    <= acc1_reg;
        exsq2_reg   <= ex1_reg * ex1_reg;
        eysq2_reg   <= ey1_reg * ey1_reg;
    end

    // Stage 2: squared corner distance against the limit.
    logic [2*HALF_W:0] dist_sq;
    logic              near;

    assign dist_sq = (2*HALF_W+1)'(exsq2_reg) + (2*HALF_W+1)'(eysq2_reg);
    assign near    = dist_sq <= (2*HALF_W+1)'(rsq);

    always_comb
    begin
        rsp.valid  = v2_reg;
        rsp.corner = corner2_reg;
        rsp.last   = corner2_reg == 2'd3;
        rsp.solid  = solid2_reg;
        rsp.oob    = oob2_reg;
        rsp.hit    = solid2_reg & ~rej2_reg & (acc2_reg | near);
    end

endmodule

// ===== src/circle_tile_map_collision.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// s_*       in         s_tvalid / s_tready      s_tdata 48 bits, s_tuser = cmd
// m_*       out        m_tvalid / m_tready      m_tdata 8 bits
// cfg_*     in         cfg_valid / cfg_ready    cfg_index 1 bit, cfg_data 16 bits
//
// After reset the tile memory is swept to open, one tile per cycle, so input
// transfers are held off until all MAP_COLS * MAP_ROWS tiles (4096 at the defaults)
// are cleared. Tile writes are then taken back to back. A query keeps the input
// channel closed from its transfer to the loading of its result: four reads of
// the single-port tile memory, one per corner, then the tile test pipeline, then
// the result register. A result waiting on m_tready does not stop tile writes; the
// next query's result waits in the done state until the result register is free.
// Configuration is taken at any time, and is meant to change only while idle.

module circle_tile_map_collision #(
    parameter int MAP_COLS = 64,
    parameter int MAP_ROWS = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // tile_col[5:0], tile_row[11:6], tile_solid[12], pos_x[27:13], pos_y[42:28]
    input  logic [47:0] s_tdata,
    // cmd[0]
    input  logic [0:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // hit[0], solid_corners[4:1], out_of_map[5]
    output logic [7:0]  m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import ctm_pkg::*;

    localparam int DEPTH = MAP_COLS * MAP_ROWS;
    localparam int AW    = $clog2(DEPTH);

    // Configuration registers. The port is always ready: writes are only
    // expected while no query is in flight.
    logic [HALF_W-1:0] probe_half_reg;
    logic [RSQ_W-1:0]  corner_rsq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_half_reg <= HALF_W'(128);
            corner_rsq_reg <= RSQ_W'(16384);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PROBE_HALF: probe_half_reg <= cfg_data[HALF_W-1:0];
                CFG_CORNER_RSQ: corner_rsq_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input unpacking.
    in_data_t in_data;
    logic     in_query;
    logic     wr_in_grid;
    logic [21:0] wr_lin;

    assign in_data    = in_data_t'(s_tdata[$bits(in_data_t)-1:0]);
    assign in_query   = cmd_t'(s_tuser[0]) == CMD_QUERY;
    assign wr_in_grid = (12'(in_data.tile_col) < 12'(MAP_COLS)) &&
                        (12'(in_data.tile_row) < 12'(MAP_ROWS));
    assign wr_lin     = 22'(in_data.tile_row) * 22'(MAP_COLS) + 22'(in_data.tile_col);

    // Sequencer state.
    state_t        state_reg;
    state_t        state_next;
    logic [1:0]    k_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [POS_W-1:0] px_reg;
    logic [POS_W-1:0] py_reg;

    // Corner tile indices, computed as a query is taken.
    logic      corner_ld;
    tile_idx_t col_lo;
    tile_idx_t col_hi;
    tile_idx_t row_lo;
    tile_idx_t row_hi;

    ctm_corner u_corner_x (
        .clk    (clk),
        .ld     (corner_ld),
        .pos    (in_data.pos_x),
        .half   (probe_half_reg),
        .idx_lo (col_lo),
        .idx_hi (col_hi)
    );

    ctm_corner u_corner_y (
        .clk    (clk),
        .ld     (corner_ld),
        .pos    (in_data.pos_y),
        .half   (probe_half_reg),
        .idx_lo (row_lo),
        .idx_hi (row_hi)
    );

    // Corner chosen for this read: bit 0 of the count picks the column, bit 1
    // the row, matching the order of the solid_corners mask.
    tile_idx_t   rd_col;
    tile_idx_t   rd_row;
    logic        rd_in_grid;
    logic [21:0] rd_lin;

    assign rd_col     = k_reg[0] ? col_hi : col_lo;
    assign rd_row     = k_reg[1] ? row_hi : row_lo;
    assign rd_in_grid = !rd_col[TIDX_W-1] && !rd_row[TIDX_W-1] &&
                        (12'(rd_col) < 12'(MAP_COLS)) && (12'(rd_row) < 12'(MAP_ROWS));
    assign rd_lin     = 22'(rd_row[TIDX_W-2:0]) * 22'(MAP_COLS) +
                        22'(rd_col[TIDX_W-2:0]);

    // Tile memory.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic          ram_wdata;
    logic          ram_rdata;

    ctm_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_tile_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Tile test pipeline; the memory read data meets it in the cycle after issue.
    tt_req_t tt_req;
    tt_rsp_t tt_rsp;

    ctm_tile_test u_tile_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (tt_req),
        .map_solid (ram_rdata),
        .half      (probe_half_reg),
        .rsq       (corner_rsq_reg),
        .rsp       (tt_rsp)
    );

    // Result register.
    logic       res_valid_reg;
    logic       res_hit_reg;
    logic [3:0] res_mask_reg;
    logic       res_oom_reg;
    logic       res_load;

    // Per-query accumulators.
    logic       acc_hit_reg;
    logic [3:0] acc_mask_reg;
    logic       acc_oom_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid && in_query)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (tt_rsp.valid && tt_rsp.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory port, handshake, pipeline feed.
    always_comb
    begin
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = rd_lin[AW-1:0];
        ram_wdata     = 1'b0;
        corner_ld     = 1'b0;
        res_load      = 1'b0;
        tt_req.valid  = 1'b0;
        tt_req.corner = k_reg;
        tt_req.oob    = !rd_in_grid;
        tt_req.px     = px_reg;
        tt_req.py     = py_reg;
        tt_req.col    = rd_col;
        tt_req.row    = rd_row;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = 1'b0;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (in_query)
                    begin
                        corner_ld = 1'b1;
                    end
                    else
                    begin
                        ram_we    = wr_in_grid;
                        ram_addr  = wr_lin[AW-1:0];
                        ram_wdata = in_data.tile_solid;
                    end
                end
            end
            ST_READ:
            begin
                tt_req.valid = 1'b1;
            end
            ST_DONE:
            begin
                res_load = !res_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            k_reg         <= 2'd0;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
            begin
                k_reg <= k_reg + 2'd1;
            end
            else
            begin
                k_reg <= 2'd0;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (corner_ld)
        begin
            px_reg       <= in_data.pos_x;
            py_reg       <= in_data.pos_y;
            acc_hit_reg  <= 1'b0;
            acc_mask_reg <= 4'd0;
            acc_oom_reg  <= 1'b0;
        end
        else if (tt_rsp.valid)
        begin
            acc_hit_reg                <= acc_hit_reg | tt_rsp.hit;
            acc_mask_reg[tt_rsp.corner] <= tt_rsp.solid;
            acc_oom_reg                <= acc_oom_reg | tt_rsp.oob;
        end
        if (res_load)
        begin
            res_hit_reg  <= acc_hit_reg;
            res_mask_reg <= acc_mask_reg;
            res_oom_reg  <= acc_oom_reg;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {2'b00, res_oom_reg, res_mask_reg, res_hit_reg};

    // The clearing sweep keeps the input channel closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken during the clearing sweep");

    // Memory writes never collide with the corner reads.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("tile write while reading corners");

    // Corner outcomes only appear while a query is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        tt_rsp.valid |-> (state_reg == ST_READ || state_reg == ST_DRAIN))
        else $error("corner outcome outside a query");

    // The last corner closes the query.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tt_rsp.valid && tt_rsp.last) |=> (state_reg == ST_DONE))
        else $error("query not closed after its last corner");

    // An off-grid corner is always reported solid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tt_rsp.valid && tt_rsp.oob) |-> tt_rsp.solid)
        else $error("off-grid corner not marked solid");

endmodule
